>>> rtl/core/fcp_pkg.sv
// ---------------------------------------------------------------------------
// fcp_pkg
// Shared types and constants of the FORM chunk table parser.
// ---------------------------------------------------------------------------
package fcp_pkg;

	localparam int MAX_CHUNKS_DEF = 64;

	localparam logic [31:0] MAGIC_FORM   = 32'h4D52_4F46;
	localparam logic [31:0] MIN_FILE_LEN = 32'd12;
	localparam int          HDR_LEN      = 8;

	localparam int NAME_W   = 32;
	localparam int ENTRY_W  = 96;   // {length, offset, name}
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 112;

	typedef enum logic [1:0] {
		KIND_RECORD,
		KIND_STATUS,
		KIND_LOOKUP
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_SHORT,
		ST_BAD_MAGIC,
		ST_FULL
	} status_t;

	typedef struct packed {
		kind_t       kind;
		status_t     status;
		logic        found;
		logic [5:0]  index;
		logic [31:0] name;
		logic [31:0] offset;
		logic [31:0] length;
		logic        last;
	} result_t;

endpackage

>>> rtl/core/fcp_ram.sv
// ---------------------------------------------------------------------------
// fcp_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module fcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/fcp_parser.sv
// ---------------------------------------------------------------------------
// fcp_parser
// Byte-path parse state: form header, chunk headers, table appends.
// ---------------------------------------------------------------------------
module fcp_parser #(
	parameter int MAX_CHUNKS = fcp_pkg::MAX_CHUNKS_DEF,
	localparam int AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1,
	localparam int CW = $clog2(MAX_CHUNKS + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [7:0]             byte_value,
	input  logic                   last_byte,
	input  logic [31:0]            file_length,
	output logic [1:0]             res_count,
	output fcp_pkg::result_t       res0,
	output fcp_pkg::result_t       res1,
	output logic                   wr_en,
	output logic [AW-1:0]          wr_addr,
	output logic [fcp_pkg::ENTRY_W-1:0] wr_data,
	output logic [CW-1:0]          entry_count
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_CHUNKS,
		PH_DONE
	} phase_t;

	localparam logic [32:0] POS_MAX = '1;

	phase_t      phase_q, phase_d;
	logic [32:0] pos_q, pos_d;
	logic [32:0] form_end_q, form_end_d;
	logic [32:0] lim_q, lim_d;          // form end less one header
	logic [33:0] hdr_pos_q, hdr_pos_d;
	logic [55:0] hdr_q, hdr_d;          // first seven header bytes
	logic [CW-1:0] count_q, count_d;

	logic [31:0] name_c, magic_c, size_c;
	logic [34:0] off_c, end_c;
	logic [32:0] fend_c;
	logic [2:0]  slot_c;
	logic        in_hdr_c;
	logic        rec_v, stat_v;
	fcp_pkg::status_t st_c;
	logic [CW+5:0] idx_wide;
	fcp_pkg::result_t rec_r, stat_r;

	// magic: three stored bytes plus the incoming one; name: four stored bytes
	assign magic_c  = {byte_value, hdr_q[23:0]};
	assign name_c   = hdr_q[31:0];
	assign size_c   = {byte_value, hdr_q[55:32]};
	assign off_c    = {1'b0, hdr_pos_q} + 35'd8;
	assign end_c    = off_c + {3'b000, size_c};
	assign fend_c   = 33'd8 + {1'b0, size_c};
	assign in_hdr_c = ({2'b00, pos_q} >= {1'b0, hdr_pos_q}) && ({2'b00, pos_q} < off_c);
	assign slot_c   = pos_q[2:0] - hdr_pos_q[2:0];
	assign idx_wide = {6'b000000, count_q};

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		form_end_d = form_end_q;
		lim_d      = lim_q;
		hdr_pos_d  = hdr_pos_q;
		hdr_d      = hdr_q;
		count_d    = count_q;
		rec_v      = 1'b0;
		stat_v     = 1'b0;
		st_c       = fcp_pkg::ST_OK;

		unique case (phase_q)
			PH_HEADER: begin
				if (pos_q == 33'd0 && file_length < fcp_pkg::MIN_FILE_LEN) begin
					stat_v  = 1'b1;
					st_c    = fcp_pkg::ST_SHORT;
					phase_d = PH_DONE;
				end else if (pos_q < 33'd8) begin
					if (pos_q[2:0] != 3'd7) begin
						hdr_d[{pos_q[2:0], 3'b000} +: 8] = byte_value;
					end
					if (pos_q == 33'd3 && magic_c != fcp_pkg::MAGIC_FORM) begin
						stat_v  = 1'b1;
						st_c    = fcp_pkg::ST_BAD_MAGIC;
						phase_d = PH_DONE;
					end else if (pos_q == 33'd7) begin
						form_end_d = (fend_c > {1'b0, file_length}) ? {1'b0, file_length}
							: fend_c;
						lim_d     = form_end_d - 33'd8;
						count_d   = '0;
						hdr_pos_d = 34'd8;
						phase_d   = PH_CHUNKS;
						if (form_end_d < 33'd16) begin
							stat_v  = 1'b1;
							phase_d = PH_DONE;
						end
					end
				end
			end
			PH_CHUNKS: begin
				if (in_hdr_c) begin
					if (slot_c != 3'd7) begin
						hdr_d[{slot_c, 3'b000} +: 8] = byte_value;
					end else if (end_c > {2'b00, form_end_q}) begin
						stat_v  = 1'b1;
						phase_d = PH_DONE;
					end else if (count_q >= CW'(MAX_CHUNKS)) begin
						stat_v  = 1'b1;
						st_c    = fcp_pkg::ST_FULL;
						phase_d = PH_DONE;
					end else begin
						rec_v     = 1'b1;
						count_d   = count_q + 1'b1;
						hdr_pos_d = end_c[33:0];
						if (end_c > {2'b00, lim_q}) begin
							stat_v  = 1'b1;
							phase_d = PH_DONE;
						end
					end
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		// Close an open parse on the final byte, then rewind for the next file.
		if (last_byte) begin
			if (phase_d == PH_HEADER) begin
				stat_v = 1'b1;
				st_c   = fcp_pkg::ST_SHORT;
			end else if (phase_d == PH_CHUNKS) begin
				stat_v = 1'b1;
			end
			pos_d     = '0;
			phase_d   = PH_HEADER;
			hdr_pos_d = 34'd8;
			hdr_d     = '0;
		end else if (pos_q != POS_MAX) begin
			pos_d = pos_q + 1'b1;
		end
	end

	always_comb begin
		rec_r        = '0;
		rec_r.kind   = fcp_pkg::KIND_RECORD;
		rec_r.index  = idx_wide[5:0];
		rec_r.name   = name_c;
		rec_r.offset = off_c[31:0];
		rec_r.length = size_c;
		rec_r.last   = !stat_v;

		stat_r        = '0;
		stat_r.kind   = fcp_pkg::KIND_STATUS;
		stat_r.status = st_c;
		stat_r.last   = 1'b1;

		res0      = rec_v ? rec_r : stat_r;
		res1      = stat_r;
		res_count = {1'b0, rec_v} + {1'b0, stat_v};
	end

	assign wr_en       = accept && rec_v;
	assign wr_addr     = count_q[AW-1:0];
	assign wr_data     = {size_c, off_c[31:0], name_c};
	assign entry_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			pos_q      <= '0;
			form_end_q <= '0;
			lim_q      <= '0;
			hdr_pos_q  <= 34'd8;
			hdr_q      <= '0;
			count_q    <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			form_end_q <= form_end_d;
			lim_q      <= lim_d;
			hdr_pos_q  <= hdr_pos_d;
			hdr_q      <= hdr_d;
			count_q    <= count_d;
		end
	end

endmodule

>>> rtl/core/fcp_lookup.sv
// ---------------------------------------------------------------------------
// fcp_lookup
// Name search over the chunk table, one entry read per cycle.
// ---------------------------------------------------------------------------
module fcp_lookup #(
	parameter int MAX_CHUNKS = fcp_pkg::MAX_CHUNKS_DEF,
	localparam int AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1,
	localparam int CW = $clog2(MAX_CHUNKS + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [31:0]            query_name,
	input  logic [CW-1:0]          entry_count,
	output logic                   rd_en,
	output logic [AW-1:0]          rd_addr,
	input  logic [fcp_pkg::ENTRY_W-1:0] rd_data,
	output logic                   busy,
	output logic                   done,
	output fcp_pkg::result_t       res
);

	logic          busy_q;
	logic [CW-1:0] rd_idx_q;
	logic          pend_s1;
	logic [AW-1:0] idx_s1;
	logic [31:0]   query_q;
	logic          match;
	logic [AW+5:0] idx_wide;

	assign match    = pend_s1 && (rd_data[31:0] == query_q);
	assign done     = busy_q && (match || rd_idx_q >= entry_count);
	assign rd_en    = busy_q && !match && (rd_idx_q < entry_count);
	assign rd_addr  = rd_idx_q[AW-1:0];
	assign busy     = busy_q;
	assign idx_wide = {6'b000000, idx_s1};

	always_comb begin
		res      = '0;
		res.kind = fcp_pkg::KIND_LOOKUP;
		res.last = 1'b1;
		if (match) begin
			res.found  = 1'b1;
			res.index  = idx_wide[5:0];
			res.name   = rd_data[31:0];
			res.offset = rd_data[63:32];
			res.length = rd_data[95:64];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			rd_idx_q <= '0;
			pend_s1  <= 1'b0;
		end else if (start) begin
			busy_q   <= 1'b1;
			rd_idx_q <= '0;
			pend_s1  <= 1'b0;
		end else if (busy_q) begin
			if (done) begin
				busy_q  <= 1'b0;
				pend_s1 <= 1'b0;
			end else begin
				pend_s1  <= rd_en;
				rd_idx_q <= rd_idx_q + CW'(rd_en);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			query_q <= query_name;
		end
		if (rd_en) begin
			idx_s1 <= rd_idx_q[AW-1:0];
		end
	end

endmodule

>>> rtl/core/form_chunk_table_parser.sv
// ---------------------------------------------------------------------------
// form_chunk_table_parser
// FORM container parser with little-endian sizes and a fixed chunk table.
// ---------------------------------------------------------------------------
// Stream a file in one byte per input word (tuser = 0), or send a lookup
// (tuser = 1, name in tdata[39:8]). When a byte produces a chunk record
// and/or a status, the input stalls until those one or two result words are
// taken, one per cycle at best. A lookup walks the table through the single
// RAM read port, one entry per cycle, and then presents one output word.
// Chunk records are written into the RAM in the cycle their byte is
// accepted; a lookup can only start after that byte's results have left, so
// reads never overlap a pending write. Write file_length on the cfg channel
// while the block is idle, before the file starts. The table is not cleared
// after reset; only entries below the current count are ever read.
// ---------------------------------------------------------------------------
module form_chunk_table_parser #(
	parameter int MAX_CHUNKS = fcp_pkg::MAX_CHUNKS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [fcp_pkg::IN_TDATA_W-1:0]  s_tdata,  // byte_value[7:0], query_name[39:8]
	input  logic                            s_tuser,  // action
	input  logic                            s_tlast,  // last_byte
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [fcp_pkg::OUT_TDATA_W-1:0] m_tdata,  // status[1:0], found[2],
	                                                  // chunk_index[8:3], chunk_name[40:9],
	                                                  // chunk_offset[72:41],
	                                                  // chunk_length[104:73], zero[111:105]
	output logic [1:0]                      m_tuser,  // result_kind
	output logic                            m_tlast,  // last_result
	// configuration: file_length
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [31:0]                     cfg_data
);

	localparam int AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int CW = $clog2(MAX_CHUNKS + 1);

	logic [31:0] file_length_q;

	// output buffer: up to two results per input word
	fcp_pkg::result_t res0_q, res1_q;
	logic [1:0]       cnt_q;

	logic             byte_acc, look_acc, out_acc;
	logic [1:0]       p_count;
	fcp_pkg::result_t p_res0, p_res1, lk_res;
	logic             wr_en, rd_en, lk_busy, lk_done;
	logic [AW-1:0]    wr_addr, rd_addr;
	logic [fcp_pkg::ENTRY_W-1:0] wr_data, rd_data;
	logic [CW-1:0]    entry_count;

	// take input only with an empty output buffer and no lookup in flight
	assign s_tready = (cnt_q == 2'd0) && !lk_busy;
	assign byte_acc = s_tvalid && s_tready && !s_tuser;
	assign look_acc = s_tvalid && s_tready && s_tuser;
	assign out_acc  = m_tvalid && m_tready;
	assign cfg_ready = 1'b1;

	fcp_parser #(
		.MAX_CHUNKS(MAX_CHUNKS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (byte_acc),
		.byte_value (s_tdata[7:0]),
		.last_byte  (s_tlast),
		.file_length(file_length_q),
		.res_count  (p_count),
		.res0       (p_res0),
		.res1       (p_res1),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.entry_count(entry_count)
	);

	fcp_lookup #(
		.MAX_CHUNKS(MAX_CHUNKS)
	) u_lookup (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (look_acc),
		.query_name (s_tdata[39:8]),
		.entry_count(entry_count),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.busy       (lk_busy),
		.done       (lk_done),
		.res        (lk_res)
	);

	// chunk table: {length, offset, name} per entry
	fcp_ram #(
		.WIDTH(fcp_pkg::ENTRY_W),
		.DEPTH(MAX_CHUNKS)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// hold the file length; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			file_length_q <= cfg_data;
		end
	end

	// result count: load from the parser or the lookup, drop one per word taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (byte_acc) begin
			cnt_q <= p_count;
		end else if (lk_done) begin
			cnt_q <= 2'd1;
		end else if (out_acc) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// result payload: advance the second slot into the head on each word taken
	always_ff @(posedge clk) begin
		if (byte_acc) begin
			res0_q <= p_res0;
			res1_q <= p_res1;
		end else if (lk_done) begin
			res0_q <= lk_res;
		end else if (out_acc) begin
			res0_q <= res1_q;
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tuser  = res0_q.kind;
	assign m_tlast  = res0_q.last;
	assign m_tdata  = {7'd0, res0_q.length, res0_q.offset, res0_q.name, res0_q.index,
		res0_q.found, res0_q.status};

endmodule
